/* hw/rtl/ins_sort_pkg.sv */
// Package for the insertion sorter: shared constants, the state type and the
// structs that pass between the sorter cells and the top level.
// No dependencies.
package ins_sort_pkg;

    localparam int unsigned DEPTH_DEF = 64;
    localparam int unsigned VAL_W     = 32;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                    insert;
        logic                    shift;
        logic signed [VAL_W-1:0] value;
    } t_ctrl;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic                    valid;
        logic                    gt;
        logic signed [VAL_W-1:0] data;
    } t_cell_out;

endpackage

/* hw/rtl/ins_sort_cell.sv */
// One compare-and-shift cell of the sorter chain.
// Depends on ins_sort_pkg.
module ins_sort_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ins_sort_pkg::t_ctrl     i_ctrl,
    input  ins_sort_pkg::t_cell_out i_lower,
    input  ins_sort_pkg::t_cell_out i_upper,
    output ins_sort_pkg::t_cell_out o_cell
);
    import ins_sort_pkg::*;

    logic                    r_valid;
    logic                    n_valid;
    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] n_data;
    logic                    gt;
    logic                    take;

    // Strict compare keeps equal values in arrival order.
    assign gt   = r_valid && (r_data > i_ctrl.value);
    // A cell takes a new entry if its own entry moves up, or if it is the
    // first empty cell of the chain.
    assign take = gt || (!r_valid && i_lower.valid);

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.shift) begin
            n_valid = i_upper.valid;
            n_data  = i_upper.data;
        end else if (i_ctrl.insert && take) begin
            n_valid = 1'b1;
            n_data  = i_lower.gt ? i_lower.data : i_ctrl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.gt    = gt;
    assign o_cell.data  = r_data;

endmodule

/* hw/rtl/insertion_sorter_core.sv */
// Top level of the insertion sorter: a chain of compare-and-shift cells and
// the fill/drain control. Depends on ins_sort_pkg and ins_sort_cell.
//
// Usage:
// The slave stream takes one signed 32-bit value per item, with tlast on the
// final value of a set. Each accepted value is inserted into the cell chain in
// the cycle it is accepted.
// Every cell compares its stored value against the arriving one in parallel;
// entries greater than the new value move up one cell, and equal values do
// not pass each other, so the order is stable.
// After the final value (tlast, or the value that fills all DEPTH cells) the block
// stops taking items and drains the set on the master stream in ascending order,
// one item per cycle while the receiver is ready, with tlast on the greatest value.
// The first result is offered in the cycle after the final value is accepted.
// Draining shifts the whole chain down one cell each time the head item is
// taken, so a stalled receiver simply holds the head item and the chain.
// The slave side becomes ready again in the cycle after the last result is taken.
// The output data comes straight from the first cell's register.
// Reset (synchronous, active low) empties the chain and returns to filling.
module insertion_sorter_core #(
    parameter int unsigned DEPTH = ins_sort_pkg::DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic signed [ins_sort_pkg::VAL_W-1:0]  s_axis_tdata,  // [31:0] value
    input  logic                                   s_axis_tlast,  // last
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic signed [ins_sort_pkg::VAL_W-1:0]  m_axis_tdata,  // [31:0] sorted_value
    output logic                                   m_axis_tlast   // final_res
);
    import ins_sort_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_ctrl     ctrl;
    t_cell_out cells [DEPTH];
    t_cell_out lower [DEPTH];
    t_cell_out upper [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    logic      in_acc;
    logic      out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    assign ctrl.insert = in_acc;
    assign ctrl.shift  = out_acc;
    assign ctrl.value  = s_axis_tdata;

    // Chain wiring: the bottom cell sees an always-valid, never-greater
    // neighbor below, and the top cell sees an empty neighbor above.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_bot
            assign lower[g] = '{valid: 1'b1, gt: 1'b0, data: '0};
        end else begin : g_mid
            assign lower[g] = cells[g-1];
        end
        if (g == DEPTH - 1) begin : g_top
            assign upper[g] = '{valid: 1'b0, gt: 1'b0, data: '0};
        end else begin : g_nxt
            assign upper[g] = cells[g+1];
        end

        ins_sort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_lower (lower[g]),
            .i_upper (upper[g]),
            .o_cell  (cells[g])
        );

        assign cell_valid[g] = cells[g].valid;
    end

    // Next state: a set ends on tlast or when this item fills the last cell.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (in_acc && (s_axis_tlast || cell_valid[DEPTH-2])) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_acc && m_axis_tlast) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            ST_FILL:  s_axis_tready = 1'b1;
            ST_DRAIN: m_axis_tvalid = cell_valid[0];
            default: begin
                s_axis_tready = 1'b0;
                m_axis_tvalid = 1'b0;
            end
        endcase
    end

    assign m_axis_tdata = cells[0].data;
    assign m_axis_tlast = !cell_valid[1];

    // Occupied cells always form a run starting at the bottom cell.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("cell chain has a hole");

    // An item with tlast starts the drain in the next cycle.
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tlast) |=> m_axis_tvalid)
        else $error("drain did not start after last item");

    // Taking the final result leaves the chain empty.
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast) |=> (cell_valid == '0))
        else $error("chain not empty after final result");

    // Results leave in ascending order.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (cells[1].data >= cells[0].data))
        else $error("drained values out of order");

endmodule
